### rtl/core/afsg_pkg.sv
`default_nettype none
package afsg_pkg;
   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;
   localparam logic [15:0] REHASH_LIMIT = 16'hFFFF;

   localparam logic [2:0] CSR_NUM_PIECES = 3'd0;
   localparam logic [2:0] CSR_FAST_SET_SIZE = 3'd1;
   localparam logic [2:0] CSR_HASH_0_7 = 3'd2;
   localparam logic [2:0] CSR_HASH_8_15 = 3'd3;
   localparam logic [2:0] CSR_HASH_16_19 = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HASH, ST_MOD, ST_SCAN, ST_SCAN_WAIT, ST_NEXT, ST_EMIT_RD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_first;
      logic load_rehash;
      logic hash_step;
      logic hash_done;
      logic mod_start;
      logic scan_clear;
      logic scan_step;
      logic append;
      logic word_next;
      logic emit_clear;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic hash_last;
      logic mod_done;
      logic scan_end;
      logic scan_hit;
      logic word_last;
      logic full;
      logic round_limit;
      logic emit_end;
   } sts_type;

   function automatic logic [31:0] sha_k(input logic [6:0] t);
      if (t < 7'd20) return 32'h5A827999;
      else if (t < 7'd40) return 32'h6ED9EBA1;
      else if (t < 7'd60) return 32'h8F1BBCDC;
      else return 32'hCA62C1D6;
   endfunction

   function automatic logic [31:0] sha_f(input logic [6:0] t, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
      if (t < 7'd20) return (b & c) | (~b & d);
      else if (t < 7'd40) return b ^ c ^ d;
      else if (t < 7'd60) return (b & c) | (b & d) | (c & d);
      else return b ^ c ^ d;
   endfunction
endpackage
`default_nettype wire

### rtl/core/afsg_ram.sv
`default_nettype none
module afsg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/afsg_ctrl.sv
`default_nettype none
module afsg_ctrl import afsg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_first = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               cmd.hash_done = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // decide what follows a finished hash or a finished word
            priority if (sts.full || sts.round_limit) begin
               cmd.emit_clear = 1'b1;
               state_in = ST_EMIT_RD;
            end else if (sts.word_last) begin
               cmd.load_rehash = 1'b1;
               state_in = ST_HASH;
            end else begin
               cmd.mod_start = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               cmd.scan_clear = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               cmd.append = 1'b1;
               cmd.word_next = 1'b1;
               state_in = ST_NEXT;
            end else begin
               cmd.scan_step = 1'b1;
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            if (sts.scan_hit) begin
               cmd.word_next = 1'b1;
               state_in = ST_NEXT;
            end else state_in = ST_SCAN;
         end
         ST_EMIT_RD: begin
            if (sts.emit_end) state_in = ST_IDLE;
            else begin
               cmd.emit_step = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: state_in = ST_EMIT_RD;
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/afsg_dp.sv
`default_nettype none
module afsg_dp import afsg_pkg::*; #(
   parameter int MAX_FAST_SET = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [31:0] peer_ipv4,
   input  wire logic [31:0] num_pieces,
   input  wire logic [6:0]  fast_set_size,
   input  wire logic [63:0] hash_0_7,
   input  wire logic [63:0] hash_8_15,
   input  wire logic [31:0] hash_16_19,
   output logic             rsp_valid,
   output logic [31:0]      rsp_piece_index,
   output logic             rsp_last_of_set
);
   localparam int AW = (MAX_FAST_SET > 1) ? $clog2(MAX_FAST_SET) : 1;
   localparam logic [6:0] MAX_SET = 7'(MAX_FAST_SET);

   logic [31:0] w_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] dig_ff [5];
   logic [6:0]  t_ff;
   logic [2:0]  word_ff;
   logic [15:0] rounds_ff;
   logic [6:0]  target_ff, count_ff, scan_ff;
   logic [31:0] rem_ff, dvd_ff, idx_ff;
   logic [5:0]  bit_ff;
   logic        mod_busy_ff;
   logic        rsp_valid_ff, rsp_last_ff;
   logic [31:0] ram_rd;

   logic [31:0] w_new, tmp, w_cur, mcipher;
   logic [32:0] rsh;
   logic [6:0]  tgt;

   assign w_cur = w_ff[0];
   assign w_new = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1
                | {31'd0, (w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31])};
   assign tmp = {a_ff[26:0], a_ff[31:27]} + sha_f(t_ff, b_ff, c_ff, d_ff) + e_ff
              + sha_k(t_ff) + w_cur;
   assign rsh = {rem_ff, dvd_ff[31]};
   assign mcipher = (rsh >= {1'b0, num_pieces}) ? 32'(rsh - {1'b0, num_pieces}) : rsh[31:0];

   always_comb begin
      tgt = fast_set_size;
      if ({25'd0, tgt} > num_pieces) tgt = num_pieces[6:0];
      if (tgt > MAX_SET) tgt = MAX_SET;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_first) begin
         w_ff[0] <= peer_ipv4 & ((peer_ipv4[31] & peer_ipv4[30]) ? 32'hFFFFFF00 : 32'hFFFF0000);
         w_ff[1] <= hash_0_7[63:32];
         w_ff[2] <= hash_0_7[31:0];
         w_ff[3] <= hash_8_15[63:32];
         w_ff[4] <= hash_8_15[31:0];
         w_ff[5] <= hash_16_19;
         w_ff[6] <= 32'h80000000;
         for (int i = 7; i < 15; i++) w_ff[i] <= '0;
         w_ff[15] <= 32'd192;
      end else if (cmd.load_rehash) begin
         for (int i = 0; i < 5; i++) w_ff[i] <= dig_ff[i];
         w_ff[5] <= 32'h80000000;
         for (int i = 6; i < 15; i++) w_ff[i] <= '0;
         w_ff[15] <= 32'd160;
      end else if (cmd.hash_step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
      if (cmd.load_first || cmd.load_rehash) begin
         a_ff <= H0; b_ff <= H1; c_ff <= H2; d_ff <= H3; e_ff <= H4;
      end else if (cmd.hash_step) begin
         a_ff <= tmp; b_ff <= a_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff; e_ff <= d_ff;
      end
      if (cmd.hash_done) begin
         dig_ff[0] <= H0 + tmp;
         dig_ff[1] <= H1 + a_ff;
         dig_ff[2] <= H2 + {b_ff[1:0], b_ff[31:2]};
         dig_ff[3] <= H3 + c_ff;
         dig_ff[4] <= H4 + d_ff;
      end
      if (cmd.mod_start) begin
         dvd_ff <= dig_ff[word_ff];
         rem_ff <= '0;
         bit_ff <= 6'd32;
      end else if (mod_busy_ff) begin
         rem_ff <= mcipher;
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         bit_ff <= bit_ff - 6'd1;
      end
      if (mod_busy_ff && bit_ff == 6'd1) idx_ff <= mcipher;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff <= '0; word_ff <= '0; rounds_ff <= '0; target_ff <= '0;
         count_ff <= '0; scan_ff <= '0; mod_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0; rsp_last_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_step;
         rsp_last_ff <= cmd.emit_step && (scan_ff + 7'd1 == count_ff);
         if (cmd.load_first) begin
            target_ff <= tgt;
            count_ff <= '0;
            rounds_ff <= '0;
         end
         if (cmd.load_first || cmd.load_rehash) t_ff <= '0;
         else if (cmd.hash_step) t_ff <= t_ff + 7'd1;
         if (cmd.hash_done) word_ff <= '0;
         else if (cmd.word_next) word_ff <= word_ff + 3'd1;
         if (cmd.load_rehash) rounds_ff <= rounds_ff + 16'd1;
         if (cmd.mod_start) mod_busy_ff <= 1'b1;
         else if (mod_busy_ff && bit_ff == 6'd1) mod_busy_ff <= 1'b0;
         if (cmd.scan_clear || cmd.emit_clear) scan_ff <= '0;
         else if (cmd.scan_step || cmd.emit_step) scan_ff <= scan_ff + 7'd1;
         if (cmd.append) count_ff <= count_ff + 7'd1;
      end
   end

   afsg_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_set (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (idx_ff),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (ram_rd)
   );

   // ram_rd holds entry scan_ff-1 while waiting
   assign sts.hash_last = (t_ff == 7'd79);
   assign sts.mod_done = mod_busy_ff && bit_ff == 6'd1;
   assign sts.scan_end = (scan_ff == count_ff);
   assign sts.scan_hit = (ram_rd == idx_ff);
   assign sts.word_last = (word_ff == 3'd5);
   assign sts.full = (count_ff >= target_ff);
   assign sts.round_limit = sts.word_last && (rounds_ff == REHASH_LIMIT);
   assign sts.emit_end = (scan_ff == count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_piece_index = ram_rd;
   assign rsp_last_of_set = rsp_last_ff;
endmodule
`default_nettype wire

### rtl/core/allowed_fast_set_generator_top.sv
// Each digest comes from one SHA-1 block; each digest word takes a bit-serial modulo
// and a scan of the stored indices; the results then stream out of the set.
// One request at a time; busy stays high until the last result has been shown.
// The receiver cannot stall. Synchronous reset clears the control state and counters
// and loads the CSR defaults; the hash and modulo datapath registers are not reset.
`default_nettype none
module allowed_fast_set_generator_top import afsg_pkg::*; #(
   parameter int MAX_FAST_SET = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_peer_ipv4,
   output logic             rsp_valid,
   output logic [31:0]      rsp_piece_index,
   output logic             rsp_last_of_set,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wr_data
);
   cmd_type cmd;
   sts_type sts;
   logic [31:0] num_pieces_ff, hash_16_19_ff;
   logic [6:0]  fast_set_size_ff;
   logic [63:0] hash_0_7_ff, hash_8_15_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_pieces_ff <= 32'd1; fast_set_size_ff <= 7'd10;
         hash_0_7_ff <= '0; hash_8_15_ff <= '0; hash_16_19_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_PIECES: num_pieces_ff <= csr_wr_data[31:0];
            CSR_FAST_SET_SIZE: fast_set_size_ff <= csr_wr_data[6:0];
            CSR_HASH_0_7: hash_0_7_ff <= csr_wr_data;
            CSR_HASH_8_15: hash_8_15_ff <= csr_wr_data;
            CSR_HASH_16_19: hash_16_19_ff <= csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   afsg_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
   );

   afsg_dp #(.MAX_FAST_SET(MAX_FAST_SET)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .peer_ipv4(req_peer_ipv4),
      .num_pieces(num_pieces_ff), .fast_set_size(fast_set_size_ff),
      .hash_0_7(hash_0_7_ff), .hash_8_15(hash_8_15_ff), .hash_16_19(hash_16_19_ff),
      .rsp_valid(rsp_valid), .rsp_piece_index(rsp_piece_index),
      .rsp_last_of_set(rsp_last_of_set)
   );
endmodule
`default_nettype wire

### rtl/core/afsg_checker.sv
`default_nettype none
module afsg_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_last_of_set
);
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_set |-> rsp_valid) else $error("last without valid");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results too close");
endmodule

bind allowed_fast_set_generator_top afsg_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_last_of_set(rsp_last_of_set)
);
`default_nettype wire
